FILE: rtl/lpr_pkg.sv
// Package for the line pixel rasterizer: coordinate and decision types,
// stream widths and command codes. Self-contained and used by every rtl file.
package lpr_pkg;

  // Coordinate width. The stream fields are fixed at this width.
  localparam int COORD_BITS = 12;
  // The signed decision term needs four bits of headroom over a coordinate.
  localparam int DEC_BITS = COORD_BITS + 4;

  // The four endpoint coordinates and the two pixel coordinates are padded to whole bytes.
  localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0] coord_diff_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

endpackage

FILE: rtl/line_pixel_rasterizer.sv
// Line pixel rasterizer top level: Bresenham set-up and pixel stepping.
// Depends on lpr_pkg for types, widths and command codes.
// A step's pixel moves from the input register into the result register, and
// from there shows on the master side; a master-side stall can hold it back.
// Throughput: one transaction per cycle while the master side does not stall.
// Reset (rst, synchronous, active high) empties both registers; the block is idle.
module line_pixel_rasterizer (
  input  logic                            clk,
  input  logic                            rst,
  // Slave side. tdata from bit 0 up: x_start, y_start, x_end, y_end.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lpr_pkg::IN_DATA_BITS-1:0] s_axis_tdata,
  // tuser: command (0 loads a segment, 1 emits the next pixel).
  input  logic                            s_axis_tuser,
  // Master side. tdata from bit 0 up: pixel_x, pixel_y. tlast: last_pixel.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lpr_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic                            m_axis_tlast
);
  import lpr_pkg::*;

  // ---------------------------------------------------------------------
  // Input register. It holds one transaction until the processing stage
  // takes it. The stage moves whenever the result register is free or
  // is being drained in the same cycle, so a fresh transaction can be
  // accepted every cycle while no finished pixel waits downstream.
  // ---------------------------------------------------------------------
  logic   in_valid;
  cmd_t   in_cmd;
  coord_t in_xs, in_ys, in_xe, in_ye;

  logic   proc_fire;
  logic   s_fire;

  assign proc_fire     = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || proc_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (proc_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_cmd <= cmd_t'(s_axis_tuser);
      in_xs  <= s_axis_tdata[COORD_BITS-1:0];
      in_ys  <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      in_xe  <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
      in_ye  <= s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
    end
  end

  // ---------------------------------------------------------------------
  // Segment state.
  // ---------------------------------------------------------------------
  coord_t major_pos, minor_pos, pixels_left;
  dec_t   decision, inc_when_low, inc_when_high;
  logic   minor_falls, axes_swapped, active;

  // ---------------------------------------------------------------------
  // Load set-up. Both signed differences are formed in parallel. The
  // major axis is y only when |dy| is strictly larger (a tie keeps x).
  // If the major difference is negative, the endpoints are traversed in
  // reverse, which negates the minor difference and starts from the end point.
  // ---------------------------------------------------------------------
  coord_diff_t dx, dy, dmin_raw, dmin;
  coord_t      adx, ady, dmaj;
  logic        swap_axes, flip;
  dec_t        dmin_w, dmaj_w;
  dec_t        ld_inc_low, ld_inc_high, ld_decision;
  coord_t      ld_major, ld_minor;

  always_comb begin
    dx        = coord_diff_t'({1'b0, in_xe}) - coord_diff_t'({1'b0, in_xs});
    dy        = coord_diff_t'({1'b0, in_ye}) - coord_diff_t'({1'b0, in_ys});
    adx       = dx[COORD_BITS] ? coord_t'(-dx) : dx[COORD_BITS-1:0];
    ady       = dy[COORD_BITS] ? coord_t'(-dy) : dy[COORD_BITS-1:0];
    swap_axes = ady > adx;
    dmaj      = swap_axes ? ady : adx;
    flip      = swap_axes ? dy[COORD_BITS] : dx[COORD_BITS];
    dmin_raw  = swap_axes ? dx : dy;
    dmin      = flip ? -dmin_raw : dmin_raw;
    dmin_w    = DEC_BITS'(dmin);
    dmaj_w    = dec_t'({{(DEC_BITS-COORD_BITS){1'b0}}, dmaj});

    if (swap_axes) begin
      ld_major = flip ? in_ye : in_ys;
      ld_minor = flip ? in_xe : in_xs;
    end else begin
      ld_major = flip ? in_xe : in_xs;
      ld_minor = flip ? in_ye : in_ys;
    end

    // Rising minor: the high case steps the minor up. Falling minor: the
    // low case steps it down.
    if (dmin_w > 0) begin
      ld_inc_low  = dmin_w <<< 1;
      ld_inc_high = (dmin_w - dmaj_w) <<< 1;
      ld_decision = (dmin_w <<< 1) - dmaj_w;
    end else begin
      ld_inc_low  = (dmin_w + dmaj_w) <<< 1;
      ld_inc_high = dmin_w <<< 1;
      ld_decision = (dmin_w <<< 1) + dmaj_w;
    end
  end

  // ---------------------------------------------------------------------
  // Pixel stepping. The current pixel is emitted, then the position
  // advances one along the major axis and the decision term picks the
  // minor move. The last pixel only returns the block to idle.
  // ---------------------------------------------------------------------
  logic   step_emit;
  logic   is_last;
  logic   take_low;
  coord_t px, py;

  always_comb begin
    step_emit = proc_fire && (in_cmd == CMD_STEP) && active;
    is_last   = pixels_left == '0;
    take_low  = decision <= 0;
    px        = axes_swapped ? minor_pos : major_pos;
    py        = axes_swapped ? major_pos : minor_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      major_pos     <= '0;
      minor_pos     <= '0;
      pixels_left   <= '0;
      decision      <= '0;
      inc_when_low  <= '0;
      inc_when_high <= '0;
      minor_falls   <= 1'b0;
      axes_swapped  <= 1'b0;
      active        <= 1'b0;
    end else if (proc_fire && (in_cmd == CMD_LOAD)) begin
      // A load replaces any segment that is still running.
      major_pos     <= ld_major;
      minor_pos     <= ld_minor;
      pixels_left   <= dmaj;
      decision      <= ld_decision;
      inc_when_low  <= ld_inc_low;
      inc_when_high <= ld_inc_high;
      minor_falls   <= !(dmin_w > 0);
      axes_swapped  <= swap_axes;
      active        <= 1'b1;
    end else if (step_emit) begin
      if (is_last) begin
        active <= 1'b0;
      end else begin
        major_pos   <= major_pos + 1'b1;
        pixels_left <= pixels_left - 1'b1;
        if (take_low) begin
          decision <= decision + inc_when_low;
          if (minor_falls) begin
            minor_pos <= minor_pos - 1'b1;
          end
        end else begin
          decision <= decision + inc_when_high;
          if (!minor_falls) begin
            minor_pos <= minor_pos + 1'b1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register. The register is loaded only by a step on an active
  // segment. It empties when the pixel is taken and nothing replaces it.
  // ---------------------------------------------------------------------
  coord_t out_x, out_y;
  logic   out_last;
  logic   out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire) begin
      out_valid <= step_emit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_emit) begin
      out_x    <= px;
      out_y    <= py;
      out_last <= is_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DATA_BITS'({out_y, out_x});
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  // A processed load always leaves a segment running.
  a_load_activates: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && (in_cmd == CMD_LOAD)) |=> active)
    else $error("segment not active after load");

  // Emitting the final pixel of a segment returns the block to idle.
  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (step_emit && is_last) |=> (!active && m_axis_tvalid && m_axis_tlast))
    else $error("last pixel did not end the segment");

  // A step with no running segment produces no result.
  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && (in_cmd == CMD_STEP) && !active) |=> !m_axis_tvalid)
    else $error("result produced while idle");
`endif

endmodule

FILE: test/lpr_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the line pixel rasterizer test: a Bresenham predictor fed with
// accepted commands, and the queue of pixels that the block still owes.
// Depends on lpr_pkg for the coordinate, decision and command types.
package lpr_scoreboard_pkg;
  import lpr_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  class line_pixel_scoreboard;
    // Predicted segment state, in major/minor axis terms.
    coord_t major_at;
    coord_t minor_at;
    coord_t steps_left;
    dec_t   err_term;
    dec_t   err_step_low;
    dec_t   err_step_high;
    bit     minor_down;
    bit     steep;
    bit     drawing;

    pixel_t owed_pixels[$];
    int unsigned mismatches;

    function void clear();
      major_at      = '0;
      minor_at      = '0;
      steps_left    = '0;
      err_term      = '0;
      err_step_low  = '0;
      err_step_high = '0;
      minor_down    = 1'b0;
      steep         = 1'b0;
      drawing       = 1'b0;
      owed_pixels.delete();
      mismatches    = 0;
    endfunction

    function int unsigned owed();
      return owed_pixels.size();
    endfunction

    function void start_segment(coord_t xa, coord_t ya, coord_t xb, coord_t yb);
      int adx, ady, ma, na, mb, nb, t, dmaj, dmin;
      adx = (xb > xa) ? int'(xb) - int'(xa) : int'(xa) - int'(xb);
      ady = (yb > ya) ? int'(yb) - int'(ya) : int'(ya) - int'(yb);
      // A tie keeps x as the major axis.
      steep = ady > adx;
      if (steep) begin
        ma = ya; na = xa; mb = yb; nb = xb;
      end else begin
        ma = xa; na = ya; mb = xb; nb = yb;
      end
      if (mb < ma) begin
        t = ma; ma = mb; mb = t;
        t = na; na = nb; nb = t;
      end
      dmaj = mb - ma;
      dmin = nb - na;
      // A flat minor counts as falling; the low case, which would move it down, is never reached.
      minor_down = dmin <= 0;
      if (!minor_down) begin
        err_step_low  = dec_t'(2 * dmin);
        err_step_high = dec_t'(2 * dmin - 2 * dmaj);
        err_term      = dec_t'(2 * dmin - dmaj);
      end else begin
        err_step_low  = dec_t'(2 * dmin + 2 * dmaj);
        err_step_high = dec_t'(2 * dmin);
        err_term      = dec_t'(2 * dmin + dmaj);
      end
      major_at   = coord_t'(ma);
      minor_at   = coord_t'(na);
      steps_left = coord_t'(dmaj);
      drawing    = 1'b1;
    endfunction

    // Called for every accepted input transaction.
    function void accept_command(cmd_t cmd, logic [IN_DATA_BITS-1:0] data);
      pixel_t px;
      if (cmd == CMD_LOAD) begin
        start_segment(data[0 +: COORD_BITS], data[COORD_BITS +: COORD_BITS],
                      data[2*COORD_BITS +: COORD_BITS], data[3*COORD_BITS +: COORD_BITS]);
        return;
      end
      if (!drawing) return;
      px.x    = steep ? minor_at : major_at;
      px.y    = steep ? major_at : minor_at;
      px.last = steps_left == '0;
      owed_pixels.insert(owed_pixels.size(), px);
      if (px.last) begin
        drawing = 1'b0;
      end else begin
        major_at = major_at + 1'b1;
        if (err_term <= 0) begin
          if (minor_down) minor_at = minor_at - 1'b1;
          err_term = err_term + err_step_low;
        end else begin
          if (!minor_down) minor_at = minor_at + 1'b1;
          err_term = err_term + err_step_high;
        end
        steps_left = steps_left - 1'b1;
      end
    endfunction

    // Called for every accepted output transaction.
    function void check_pixel(logic [OUT_DATA_BITS-1:0] data, logic last);
      pixel_t want;
      if (owed_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected pixel x=%0d y=%0d last=%b", $time,
                   data[0 +: COORD_BITS], data[COORD_BITS +: COORD_BITS], last);
        return;
      end
      want = owed_pixels.pop_front();
      if (data[0 +: COORD_BITS] !== want.x || data[COORD_BITS +: COORD_BITS] !== want.y ||
          last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: pixel expected x=%0d y=%0d last=%b, got x=%0d y=%0d last=%b",
                   $time, want.x, want.y, want.last,
                   data[0 +: COORD_BITS], data[COORD_BITS +: COORD_BITS], last);
      end
    endfunction
  endclass

endpackage

FILE: test/line_pixel_rasterizer_test.sv
`timescale 1ns / 100ps
// Testbench for line_pixel_rasterizer: directed and random segments checked
// pixel by pixel against a predictor, with random gaps and stalls on both sides.
// Depends on lpr_pkg, lpr_scoreboard_pkg and the rasterizer rtl.
module line_pixel_rasterizer_test;
  import lpr_pkg::*;
  import lpr_scoreboard_pkg::*;

  localparam int          COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int          TOTAL_ITEMS  = 1850;
  // The tail wait after the last owed pixel is generous.
  localparam int          DRAIN_CYCLES = 20;
  // Even in the slowest phase, with holds and stalls on each side,
  // this limit is many times what a correct run needs.
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic                     clk;
  logic                     rst           = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // From bit 0 up: x_start, y_start, x_end, y_end.
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  // command: load or step.
  logic                     s_axis_tuser  = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // From bit 0 up: pixel_x, pixel_y.
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tlast;

  // Percent chance per cycle that the sender holds off or the receiver stalls.
  int unsigned send_idle_pct = 12;
  int unsigned stall_pct     = 82;
  int unsigned stim_items;
  int unsigned cycle_count;

  line_pixel_scoreboard scoreboard;

  line_pixel_rasterizer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // All inputs change by nonblocking assignment at the rising edge, so the
  // block samples at an edge the values that were driven before that edge.
  task automatic send_item(cmd_t cmd, coord_t xa, coord_t ya, coord_t xb, coord_t yb);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {yb, xb, ya, xa};
    do @(posedge clk); while (!s_axis_tready);
    // The transaction completed at this edge.
    scoreboard.accept_command(cmd, {yb, xb, ya, xa});
  endtask

  // A step ignores its coordinates, so they are filled with noise.
  task automatic send_step();
    send_item(CMD_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom));
  endtask

  // An endpoint within span of base, clamped to the coordinate range; the
  // clamping makes the edges of the range come up often.
  function automatic coord_t near_coord(coord_t base, int span);
    int v;
    v = int'(base) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    else if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  // One random sequence: mostly a load followed by the steps that draw the
  // whole segment (sometimes with a few extra steps while idle), sometimes a
  // segment cut short so that the next load drops it, and now and then a
  // single command with random contents.
  task automatic random_sequence();
    int unsigned pick, run_len, steps;
    int          dx, dy;
    coord_t      xa, ya, xb, yb;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_item(cmd_t'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom));
      stim_items++;
      return;
    end
    xa = coord_t'($urandom);
    ya = coord_t'($urandom);
    if (pick < 13) begin
      // Endpoints anywhere: long lines, large decision terms, mostly drawn in part only.
      xb = coord_t'($urandom);
      yb = coord_t'($urandom);
    end else begin
      xb = near_coord(xa, (pick < 23) ? 100 : 15);
      yb = near_coord(ya, (pick < 23) ? 100 : 15);
    end
    dx = (xb > xa) ? int'(xb) - int'(xa) : int'(xa) - int'(xb);
    dy = (yb > ya) ? int'(yb) - int'(ya) : int'(ya) - int'(yb);
    run_len = ((dx > dy) ? dx : dy) + 1;
    if (run_len > 300 || $urandom_range(9) < 2)
      steps = $urandom_range((run_len > 20) ? 20 : run_len - 1);
    else
      steps = run_len + $urandom_range(2);
    send_item(CMD_LOAD, xa, ya, xb, yb);
    repeat (steps) send_step();
    stim_items += 1 + steps;
  endtask

  // Receiver: check every pixel transaction and draw a fresh stall decision.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      scoreboard.check_pixel(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a run that hangs ends here as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    scoreboard = new;
    scoreboard.clear();
    stim_items = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A step straight after reset finds the block idle.
    send_step();
    // Equal endpoints give one pixel marked last; the next step finds it idle.
    send_item(CMD_LOAD, 12'd5, 12'd5, 12'd5, 12'd5);
    send_step();
    send_step();
    // Full diagonal, dropped after two pixels by the next load.
    send_item(CMD_LOAD, 12'd0, 12'd0, 12'd4095, 12'd4095);
    send_step();
    send_step();
    // Horizontal, given from right to left, at the top of the range.
    send_item(CMD_LOAD, 12'd4095, 12'd4095, 12'd4092, 12'd4095);
    repeat (4) send_step();
    // Vertical, given from top to bottom.
    send_item(CMD_LOAD, 12'd7, 12'd2, 12'd7, 12'd0);
    repeat (3) send_step();
    // Equal spans on both axes keep x major; the minor falls.
    send_item(CMD_LOAD, 12'd0, 12'd4095, 12'd4095, 12'd0);
    repeat (2) send_step();
    // Steep segment: y is major and x falls as y rises.
    send_item(CMD_LOAD, 12'd10, 12'd3, 12'd8, 12'd9);
    repeat (3) send_step();
    // Equal spans again, given from right to left, left running into the random part.
    send_item(CMD_LOAD, 12'd4095, 12'd0, 12'd0, 12'd4095);
    send_step();

    // Random part in three idling phases.
    while (stim_items < TOTAL_ITEMS) begin
      if (stim_items >= 2 * TOTAL_ITEMS / 3) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end else if (stim_items >= TOTAL_ITEMS / 3) begin
        send_idle_pct = 82;
        stall_pct     = 12;
      end
      random_sequence();
    end
    s_axis_tvalid <= 1'b0;

    while (scoreboard.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scoreboard.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
rtl/lpr_pkg.sv
rtl/line_pixel_rasterizer.sv
test/lpr_scoreboard_pkg.sv
test/line_pixel_rasterizer_test.sv
